[hdl/periodic_task_tick_dispatcher_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task tick dispatcher.
// Every macro expects i_clk and i_rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_DISPATCHER_DEFINES_SVH
`define PERIODIC_TASK_TICK_DISPATCHER_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define PTD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define PTD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define PTD_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ptd_pkg.sv]
// ----------------------------------------------------------------------------
// ptd_pkg
// Request codes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_CREATE  = 3'd1;
    localparam logic [2:0] REQ_SUSPEND = 3'd2;
    localparam logic [2:0] REQ_RESUME  = 3'd3;
    localparam logic [2:0] REQ_KILL    = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic apply;   // apply a slot request (create, suspend, resume, kill)
        logic start;   // a tick was accepted: rewind the slot walk
        logic walk;    // advance the slot walk
        logic flush;   // emit the held fired id as the last beat of the tick
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done; // all slots evaluated, pipeline empty
        logic pend_vld;  // a fired id is held back
        logic out_free;  // the output register can take a beat this cycle
    } t_sts;

endpackage

[hdl/ptd_datapath.sv]
// ----------------------------------------------------------------------------
// ptd_datapath
// Slot table, two-stage slot walk, held fired id and output register.
// ----------------------------------------------------------------------------
module ptd_datapath import ptd_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic [2:0] i_req_type,
    input  logic [3:0] i_task_id,
    input  logic [7:0] i_period,
    input  logic [7:0] i_first_delay,
    input  logic       i_start_suspended,
    input  logic       i_has_handler,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [3:0] o_fired_id,
    output logic       o_last_fired
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [CW-1:0] WalkEnd = CW'(NUM_SLOTS);

    logic [NUM_SLOTS-1:0] r_present;
    logic [NUM_SLOTS-1:0] r_suspended;
    logic [7:0]           r_period_mem [NUM_SLOTS];
    logic [7:0]           r_count_mem  [NUM_SLOTS];
    logic [7:0]           r_rd_period;
    logic [7:0]           r_rd_count;

    logic [CW-1:0] r_idx;
    logic          r_s1_vld;
    logic          r_s1_act;
    logic [AW-1:0] r_s1_idx;
    logic          r_pend_vld;
    logic [3:0]    r_pend_id;
    logic          r_out_vld;
    logic [3:0]    r_out_id;
    logic          r_out_last;

    logic          id_ok;
    logic [AW-1:0] task_addr;
    logic [AW-1:0] walk_addr;
    logic          s0_busy;
    logic          s1_fire;
    logic          out_free;
    logic          stall;
    logic          adv;
    logic          walk_push;
    logic          push;
    logic          cnt_we;
    logic [7:0]    cnt_wdata;
    logic          create;

    assign id_ok     = (32'(i_task_id) < 32'(NUM_SLOTS));
    assign task_addr = AW'(i_task_id);
    assign walk_addr = r_idx[AW-1:0];
    assign s0_busy   = (r_idx != WalkEnd);
    assign s1_fire   = r_s1_vld && r_s1_act && (r_rd_count == 8'd0);
    assign out_free  = !r_out_vld || i_out_ready;
    // A second fired id can only move the held one out if the output is free.
    assign stall     = s1_fire && r_pend_vld && !out_free;
    assign adv       = i_cmd.walk && !stall;
    assign walk_push = adv && s1_fire && r_pend_vld;
    assign push      = walk_push || i_cmd.flush;
    assign cnt_we    = adv && r_s1_vld && r_s1_act;
    assign cnt_wdata = (r_rd_count == 8'd0) ? (r_rd_period - 8'd1) : (r_rd_count - 8'd1);
    assign create    = i_cmd.apply && id_ok && (i_req_type == REQ_CREATE);

    // Period and countdown tables with registered read.
    always_ff @(posedge i_clk) begin
        if (create) begin
            r_period_mem[task_addr] <= i_period;
            r_count_mem[task_addr]  <= i_first_delay;
        end else if (cnt_we) begin
            r_count_mem[r_s1_idx] <= cnt_wdata;
        end
        if (adv && s0_busy) begin
            r_rd_period <= r_period_mem[walk_addr];
            r_rd_count  <= r_count_mem[walk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_suspended <= '0;
        end else if (i_cmd.apply && id_ok) begin
            case (i_req_type)
                REQ_CREATE: begin
                    r_suspended[task_addr] <= i_start_suspended;
                    r_present[task_addr]   <= i_has_handler;
                end
                REQ_SUSPEND: begin
                    r_suspended[task_addr] <= 1'b1;
                end
                REQ_RESUME: begin
                    r_suspended[task_addr] <= 1'b0;
                end
                REQ_KILL: begin
                    r_present[task_addr] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_s1_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (i_cmd.start) begin
            r_idx      <= '0;
            r_s1_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (adv) begin
                if (s0_busy) begin
                    r_idx    <= r_idx + CW'(1);
                    r_s1_vld <= 1'b1;
                end else begin
                    r_s1_vld <= 1'b0;
                end
                if (s1_fire) begin
                    r_pend_vld <= 1'b1;
                end
            end
            if (i_cmd.flush) begin
                r_pend_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && s0_busy) begin
            r_s1_idx <= walk_addr;
            r_s1_act <= r_present[walk_addr] && !r_suspended[walk_addr];
        end
        if (adv && s1_fire) begin
            r_pend_id <= 4'(r_s1_idx);
        end
        if (push) begin
            r_out_id   <= r_pend_id;
            r_out_last <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (push) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_sts.walk_done = !s0_busy && !r_s1_vld;
    assign o_sts.pend_vld  = r_pend_vld;
    assign o_sts.out_free  = out_free;

    assign o_out_valid  = r_out_vld;
    assign o_fired_id   = r_out_id;
    assign o_last_fired = r_out_last;

endmodule

[hdl/ptd_controller.sv]
// ----------------------------------------------------------------------------
// ptd_controller
// Request sequencer: accepts requests, runs the tick walk and the final flush.
// ----------------------------------------------------------------------------
module ptd_controller import ptd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_req_type,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    assign o_cmd.apply = accept && (i_req_type != REQ_TICK);
    assign o_cmd.start = accept && (i_req_type == REQ_TICK);
    assign o_cmd.walk  = (r_state == S_WALK);
    assign o_cmd.flush = (r_state == S_FLUSH) && i_sts.pend_vld && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_vld || i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/periodic_task_tick_dispatcher.sv]
// ----------------------------------------------------------------------------
// periodic_task_tick_dispatcher
// Slot table of periodic tasks; a tick request reports every slot that is due.
// ----------------------------------------------------------------------------
// A request is one input beat. Create, suspend, resume and kill requests (and
// unknown request codes) are applied when accepted and produce no output. A
// tick request walks the NUM_SLOTS slots in index order, one slot per cycle
// while the walk is not stalled, through a two-stage pipeline around the
// period and countdown tables: the table read is registered, and the countdown
// write-back happens in the second stage. The walk stalls in every cycle in
// which a fired id has to wait for the output register because the downstream
// side has not taken the previous beat. The input is not ready during a tick.
// Each due slot gives one output beat carrying its id; the id is held back one
// step so that the final beat of the tick can carry last_fired. A tick with
// nothing due gives no output. The output register lets the next request be
// accepted while the last beat of a tick still waits to be taken. Only slots 0
// to 15 can be addressed, so slots above that never fire.
// ----------------------------------------------------------------------------
module periodic_task_tick_dispatcher import ptd_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_req_type,
    input  logic [3:0] i_task_id,
    input  logic [7:0] i_period,
    input  logic [7:0] i_first_delay,
    input  logic       i_start_suspended,
    input  logic       i_has_handler,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_fired_id,
    output logic       o_last_fired
);

    t_cmd cmd;
    t_sts sts;

    // The controller owns the request handshake and sequencing.
    ptd_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the slot table, the walk pipeline and the output beat.
    ptd_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_req_type        (i_req_type),
        .i_task_id         (i_task_id),
        .i_period          (i_period),
        .i_first_delay     (i_first_delay),
        .i_start_suspended (i_start_suspended),
        .i_has_handler     (i_has_handler),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_fired_id        (o_fired_id),
        .o_last_fired      (o_last_fired)
    );

endmodule

[hdl/ptd_checker.sv]
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks for the periodic task tick dispatcher, bound to the top.
// ----------------------------------------------------------------------------
`include "periodic_task_tick_dispatcher_defines.svh"

module ptd_checker import ptd_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [2:0] i_req_type,
    input logic       o_valid,
    input logic       i_ready,
    input logic [3:0] o_fired_id,
    input logic       o_last_fired
);

    // Reset leaves no beat pending and the request side open.
    `PTD_ASSERT_RST(a_reset_state, !i_rst_n, !o_valid && o_ready, "ptd: bad state after reset")

    // A stalled output beat holds its contents.
    `PTD_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_fired_id) && $stable(o_last_fired), "ptd: output beat changed while stalled")

    // A tick closes the request side while the slots are walked.
    `PTD_ASSERT_NXT(a_tick_busy, i_valid && o_ready && i_req_type == REQ_TICK, !o_ready, "ptd: request accepted during a tick")

    // A slot request leaves the request side ready in the following cycle.
    `PTD_ASSERT_NXT(a_req_single, i_valid && o_ready && i_req_type != REQ_TICK, o_ready, "ptd: slot request did not complete in one cycle")

    // Only existing slots can fire.
    `PTD_ASSERT_IMP(a_id_range, o_valid, int'(o_fired_id) < NUM_SLOTS, "ptd: fired id beyond the slot table")

endmodule

bind periodic_task_tick_dispatcher ptd_checker #(
    .NUM_SLOTS (NUM_SLOTS)
) u_ptd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_req_type   (i_req_type),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_fired_id   (o_fired_id),
    .o_last_fired (o_last_fired)
);

[test/periodic_task_tick_dispatcher_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_task_tick_dispatcher_test
// Self-checking bench for the periodic task tick dispatcher. Directed request
// sequences cover the corner cases of the slot table, a full-table test
// drives the widest tick, and a long random phase mixes well-formed schedules
// with noise. Every accepted request is applied to a bench-side copy of the
// slot table, and each fired-id beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module periodic_task_tick_dispatcher_test;
    import ptd_pkg::*;

    localparam int NUM_SLOTS      = 16;
    localparam int RANDOM_ITEMS   = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = NUM_SLOTS + 8;
    localparam int MAX_IDLE       = 11;

    // Request codes that the block does not define; it must drop them.
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

    // One output beat: the id of a slot that fired and the end-of-tick flag.
    typedef struct packed {
        logic [3:0] fired_id;
        logic       last_fired;
    } t_fire_beat;

    // Clock, reset and the ports of the block. Every input is known at time 0.
    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_valid           = 1'b0;
    logic       o_ready;
    logic [2:0] i_req_type        = REQ_TICK;
    logic [3:0] i_task_id         = 4'd0;
    logic [7:0] i_period          = 8'd0;
    logic [7:0] i_first_delay     = 8'd0;
    logic       i_start_suspended = 1'b0;
    logic       i_has_handler     = 1'b0;
    logic       o_valid;
    logic       i_ready           = 1'b0;
    logic [3:0] o_fired_id;
    logic       o_last_fired;

    // Bench-side copy of the slot table. It takes its reset state from its
    // initial values, since reset is applied once at the very start.
    bit       slot_live  [NUM_SLOTS];
    bit       slot_held  [NUM_SLOTS];
    bit [7:0] slot_per   [NUM_SLOTS];
    bit [7:0] slot_count [NUM_SLOTS];

    t_fire_beat  expected_fires[$];
    int unsigned mismatch_count = 0;
    int unsigned sent_count     = 0;
    int unsigned quiet_cycles   = 0;
    bit          no_idle        = 1'b0;

    periodic_task_tick_dispatcher #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (.*);

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Applies one accepted request to the slot table. A tick walks the slots
    // in index order; every live, running slot with an expired counter fires
    // and reloads period - 1 (period 0 wraps to 255), the others count down.
    // The fired ids are queued in order, the final one flagged.
    function automatic void advance_slot_table(input logic [2:0] req,
                                               input logic [3:0] id,
                                               input logic [7:0] per,
                                               input logic [7:0] dly,
                                               input logic       susp,
                                               input logic       hnd);
        logic [3:0] due_ids[$];
        t_fire_beat beat;
        if (req == REQ_TICK) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (slot_live[s] && !slot_held[s]) begin
                    if (slot_count[s] == 8'd0) begin
                        slot_count[s] = slot_per[s] - 8'd1;
                        due_ids.push_back(4'(s));
                    end else begin
                        slot_count[s] = slot_count[s] - 8'd1;
                    end
                end
            end
            foreach (due_ids[k]) begin
                beat.fired_id   = due_ids[k];
                beat.last_fired = (k == due_ids.size() - 1);
                expected_fires.push_back(beat);
            end
        end else if (int'(id) < NUM_SLOTS) begin
            case (req)
                REQ_CREATE: begin
                    // A create without a handler still loads the slot but
                    // leaves it absent.
                    slot_per[id]   = per;
                    slot_count[id] = dly;
                    slot_held[id]  = susp;
                    slot_live[id]  = hnd;
                end
                REQ_SUSPEND: begin
                    slot_held[id] = 1'b1;
                end
                REQ_RESUME: begin
                    slot_held[id] = 1'b0;
                end
                REQ_KILL: begin
                    slot_live[id] = 1'b0;
                end
                default: begin
                    // Undefined request codes leave the table untouched.
                end
            endcase
        end
    endfunction

    // Every request beat accepted at this edge goes into the prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            advance_slot_table(i_req_type, i_task_id, i_period, i_first_delay,
                               i_start_suspended, i_has_handler);
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Each accepted fired-id beat is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_fire_beat
        t_fire_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_fires.size() == 0) begin
                report_mismatch($sformatf("beat with id %0d while no slot is due",
                                          o_fired_id));
            end else begin
                want = expected_fires.pop_front();
                if (o_fired_id !== want.fired_id)
                    report_mismatch($sformatf("fired_id %0d, expected %0d",
                                              o_fired_id, want.fired_id));
                if (o_last_fired !== want.last_fired)
                    report_mismatch($sformatf("last_fired %0b on id %0d, expected %0b",
                                              o_last_fired, want.fired_id,
                                              want.last_fired));
            end
        end
    end

    // The watchdog counts cycles without a beat on either side. Even the
    // slowest legal stretch (longest sender gap, a full tick walk and the
    // longest receiver stall) stays far below the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Downstream side
    // ------------------------------------------------------------------------

    // Before each beat the receiver stalls for a random number of cycles,
    // except while no_idle asks for a stretch at full rate. Ready is only
    // lowered when a stall is drawn, so it never gets two updates in one step.
    initial begin : fire_sink
        int unsigned stall;
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Sends one request beat and returns at the edge that accepts it. Valid
    // stays high into the next call, so back-to-back requests need no bubble;
    // it is dropped only when a gap is drawn.
    task automatic send_request(input logic [2:0] req,
                                input logic [3:0] id,
                                input logic [7:0] per,
                                input logic [7:0] dly,
                                input logic       susp,
                                input logic       hnd);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_type        <= req;
        i_task_id         <= id;
        i_period          <= per;
        i_first_delay     <= dly;
        i_start_suspended <= susp;
        i_has_handler     <= hnd;
        i_valid           <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (req <= REQ_KILL)
            sent_count++;
    endtask

    // A tick ignores every field but the request code, so those carry noise.
    task automatic send_tick();
        send_request(REQ_TICK, 4'($urandom), 8'($urandom), 8'($urandom),
                     1'($urandom), 1'($urandom));
    endtask

    task automatic send_control(input logic [2:0] req, input logic [3:0] id);
        send_request(req, id, 8'($urandom), 8'($urandom), 1'($urandom),
                     1'($urandom));
    endtask

    task automatic send_create(input logic [3:0] id, input logic [7:0] per,
                               input logic [7:0] dly, input logic susp,
                               input logic hnd);
        send_request(REQ_CREATE, id, per, dly, susp, hnd);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // An empty table: ticks give no beat, controls on absent slots change
    // nothing visible, and undefined codes dressed as a create of an
    // always-due slot must not arm anything.
    task automatic test_idle_table();
        send_tick();
        send_control(REQ_KILL, 4'd3);
        send_control(REQ_SUSPEND, 4'd4);
        send_control(REQ_RESUME, 4'd4);
        for (int r = REQ_UNUSED_FIRST; r <= REQ_UNUSED_LAST; r++)
            send_request(3'(r), 4'(r), 8'd1, 8'd0, 1'b0, 1'b1);
        send_tick();
    endtask

    // Walks single slots through create, suspend, resume and kill, with the
    // period and delay extremes and a create that has no handler.
    task automatic test_slot_lifecycle();
        send_create(4'd0, 8'd0, 8'd0, 1'b0, 1'b1);      // reloads 255 after firing
        send_create(4'd15, 8'd255, 8'd255, 1'b0, 1'b1);
        send_create(4'd7, 8'd2, 8'd1, 1'b1, 1'b1);      // created suspended
        send_create(4'd9, 8'd1, 8'd0, 1'b0, 1'b0);      // no handler: stays absent
        send_tick();                                    // slot 0 alone, flagged last
        send_tick();                                    // nothing due
        send_control(REQ_RESUME, 4'd7);
        send_tick();                                    // slot 7 counts down to zero
        send_tick();                                    // slot 7 fires
        send_control(REQ_SUSPEND, 4'd9);                // absent slot, mark still set
        send_control(REQ_KILL, 4'd0);
        send_create(4'd15, 8'd255, 8'd0, 1'b0, 1'b1);
        send_create(4'd9, 8'd1, 8'd0, 1'b0, 1'b1);
        send_tick();                                    // slots 9 and 15 together
    endtask

    // Fills every slot with an expired counter so the first tick carries the
    // widest burst of beats, then thins the table out at random.
    task automatic test_all_slots_due();
        no_idle = ($urandom_range(0, 1) == 0);
        for (int s = 0; s < NUM_SLOTS; s++)
            send_create(4'(s), 8'($urandom_range(0, 2)), 8'd0, 1'b0, 1'b1);
        repeat (3) send_tick();
        for (int s = 0; s < NUM_SLOTS; s++) begin
            case ($urandom_range(0, 3))
                0: send_control(REQ_SUSPEND, 4'(s));
                1: send_control(REQ_KILL, 4'(s));
                default: begin
                end
            endcase
        end
        repeat (2) send_tick();
        no_idle = 1'b0;
    endtask

    // Mostly well-formed rounds (a few slot updates, then a run of ticks)
    // with small periods and delays so that slots fire often; now and then
    // a round of raw noise, undefined codes included. Some rounds run with
    // no idling on either side.
    task automatic test_random_schedule();
        int unsigned start_count;
        start_count = sent_count;
        while (sent_count < start_count + RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_request(3'($urandom_range(REQ_TICK, REQ_UNUSED_LAST)),
                                 4'($urandom), 8'($urandom), 8'($urandom),
                                 1'($urandom), 1'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(0, 5))
                        0, 1, 2: begin
                            send_create(4'($urandom),
                                        ($urandom_range(0, 7) == 0) ?
                                            8'($urandom) : 8'($urandom_range(0, 3)),
                                        ($urandom_range(0, 7) == 0) ?
                                            8'($urandom) : 8'($urandom_range(0, 3)),
                                        ($urandom_range(0, 3) == 0),
                                        ($urandom_range(0, 7) != 0));
                        end
                        3: send_control(REQ_SUSPEND, 4'($urandom));
                        4: send_control(REQ_RESUME, 4'($urandom));
                        default: send_control(REQ_KILL, 4'($urandom));
                    endcase
                end
                repeat ($urandom_range(1, 6)) send_tick();
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_table();
        test_slot_lifecycle();
        test_all_slots_due();
        test_random_schedule();

        // Drop valid, let the last prediction land, then drain the beats and
        // give the block a full tick walk more before the verdict.
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_fires.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/ptd_pkg.sv
hdl/ptd_datapath.sv
hdl/ptd_controller.sv
hdl/periodic_task_tick_dispatcher.sv
hdl/ptd_checker.sv
test/periodic_task_tick_dispatcher_test.sv
